FILE: design/madt_pkg.sv
// Shared types, constants and codes for the MADT entry parser.
package madt_pkg;

    localparam int CPU_SLOTS      = 16;
    localparam int OVERRIDE_SLOTS = 16;

    localparam int CPU_CNT_W = $clog2(CPU_SLOTS + 1);
    localparam int CPU_IDX_W = (CPU_SLOTS > 1) ? $clog2(CPU_SLOTS) : 1;
    localparam int OVR_CNT_W = $clog2(OVERRIDE_SLOTS + 1);
    localparam int OVR_IDX_W = (OVERRIDE_SLOTS > 1) ? $clog2(OVERRIDE_SLOTS) : 1;

    // Wide enough to compare an 8-bit query index against any slot count.
    localparam int QCMP_W = ((CPU_CNT_W > OVR_CNT_W) ? CPU_CNT_W : OVR_CNT_W) + 8;

    localparam logic [31:0] LAPIC_DEFAULT  = 32'hFEE0_0000;
    localparam logic [31:0] IOAPIC_DEFAULT = 32'hFEC0_0000;

    localparam logic [31:0] LEN_OFFSET      = 32'd4;
    localparam logic [31:0] LEN_OFFSET_LAST = 32'd7;
    localparam logic [31:0] LAPIC_OFFSET    = 32'd36;
    localparam logic [31:0] LAPIC_OFF_LAST  = 32'd39;
    localparam logic [31:0] ENTRY_START     = 32'd44;

    localparam int         CAPTURE_BYTES     = 10;
    localparam logic [7:0] MIN_ENTRY_LEN     = 8'd2;
    localparam logic [7:0] LAPIC_OVR_MIN_LEN = 8'd12;

    typedef enum logic [1:0] {
        CMD_TABLE_BYTE = 2'd0,
        CMD_QUERY_CPU  = 2'd1,
        CMD_QUERY_OVR  = 2'd2,
        CMD_UNUSED     = 2'd3
    } madt_cmd_t;

    localparam logic [7:0] KIND_CPU       = 8'd0;
    localparam logic [7:0] KIND_IOAPIC    = 8'd1;
    localparam logic [7:0] KIND_OVERRIDE  = 8'd2;
    localparam logic [7:0] KIND_LAPIC_OVR = 8'd5;

    typedef struct packed {
        logic                 table_valid;
        logic [31:0]          lapic;
        logic [31:0]          ioapic;
        logic [7:0]           ioapic_num;
        logic [31:0]          gsi_base;
        logic [CPU_CNT_W-1:0] enabled_cnt;
        logic [OVR_CNT_W-1:0] override_fill;
    } madt_status_t;

    typedef struct packed {
        logic [15:0] flags;
        logic [31:0] gsi;
        logic [7:0]  source;
    } madt_ovr_t;

    // Result word, last field in the lowest bits.
    typedef struct packed {
        logic [3:0]  pad;
        logic [15:0] override_flags;
        logic [31:0] override_gsi;
        logic [7:0]  override_source;
        logic [7:0]  cpu_apic_number;
        logic        found;
        logic [4:0]  override_count;
        logic [4:0]  enabled_cpus;
        logic [31:0] gsi_base;
        logic [7:0]  ioapic_number;
        logic [31:0] ioapic_base;
        logic [31:0] lapic_base;
        logic        table_done;
    } madt_result_t;

endpackage

FILE: design/madt_parser.sv
// Byte-wise MADT header and entry parser with the CPU and override tables.
module madt_parser (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              byte_en,
    input  logic [7:0]                        data_byte,
    input  logic [madt_pkg::CPU_IDX_W-1:0]    cpu_rd_idx,
    input  logic [madt_pkg::OVR_IDX_W-1:0]    ovr_rd_idx,
    output madt_pkg::madt_status_t            status,
    output logic [7:0]                        cpu_rd_apic,
    output madt_pkg::madt_ovr_t               ovr_rd
);
    import madt_pkg::*;

    logic [31:0]          offset_reg, offset_next;
    logic [31:0]          length_reg, length_next;
    logic [7:0]           pos_reg, pos_next;
    logic [7:0]           elen_reg, elen_next;
    logic [7:0]           kind_reg, kind_next;
    logic [7:0]           cap_reg  [CAPTURE_BYTES];
    logic [7:0]           cap_next [CAPTURE_BYTES];
    logic                 stopped_reg, stopped_next;
    logic                 valid_reg, valid_next;
    logic [31:0]          lapic_reg, lapic_next;
    logic [31:0]          ioapic_reg, ioapic_next;
    logic [7:0]           ioapic_id_reg, ioapic_id_next;
    logic [31:0]          gsi_base_reg, gsi_base_next;
    logic [CPU_CNT_W-1:0] cpu_fill_reg, cpu_fill_next;
    logic [CPU_CNT_W-1:0] enabled_cnt_reg, enabled_cnt_next;
    logic [OVR_CNT_W-1:0] ovr_fill_reg, ovr_fill_next;

    // Enabled processors are stored packed, so the nth enabled one is entry n.
    logic [7:0]           enabled_apic [CPU_SLOTS];
    madt_ovr_t            ovr_table    [OVERRIDE_SLOTS];

    logic                 commit;
    logic                 cpu_wr, ovr_wr;
    logic [31:0]          cap_word4, cap_word8;

    assign cap_word4 = {cap_next[5], cap_next[4], cap_next[3], cap_next[2]};
    assign cap_word8 = {cap_next[9], cap_next[8], cap_next[7], cap_next[6]};

    always_comb begin
        offset_next      = offset_reg;
        length_next      = length_reg;
        pos_next         = pos_reg;
        elen_next        = elen_reg;
        kind_next        = kind_reg;
        stopped_next     = stopped_reg;
        valid_next       = valid_reg;
        lapic_next       = lapic_reg;
        ioapic_next      = ioapic_reg;
        ioapic_id_next   = ioapic_id_reg;
        gsi_base_next    = gsi_base_reg;
        cpu_fill_next    = cpu_fill_reg;
        enabled_cnt_next = enabled_cnt_reg;
        ovr_fill_next    = ovr_fill_reg;
        commit           = 1'b0;
        cpu_wr           = 1'b0;
        ovr_wr           = 1'b0;
        for (int i = 0; i < CAPTURE_BYTES; i++) begin
            cap_next[i] = cap_reg[i];
        end

        if (byte_en && !valid_reg) begin
            if (offset_reg >= LEN_OFFSET && offset_reg <= LEN_OFFSET_LAST) begin
                length_next = length_reg | (32'(data_byte) << {offset_reg[1:0], 3'b000});
            end
            if (offset_reg >= LAPIC_OFFSET && offset_reg <= LAPIC_OFF_LAST) begin
                lapic_next = lapic_reg | (32'(data_byte) << {offset_reg[1:0], 3'b000});
            end

            if (offset_reg >= ENTRY_START && !stopped_reg) begin
                if (pos_reg == 8'd0) begin
                    kind_next = data_byte;
                    for (int i = 0; i < CAPTURE_BYTES; i++) begin
                        cap_next[i] = 8'd0;
                    end
                    pos_next = 8'd1;
                end else if (pos_reg == 8'd1 && data_byte < MIN_ENTRY_LEN) begin
                    // A malformed length ends entry parsing for this table.
                    elen_next    = data_byte;
                    stopped_next = 1'b1;
                    pos_next     = 8'd0;
                end else begin
                    if (pos_reg == 8'd1) begin
                        elen_next = data_byte;
                    end
                    for (int i = 0; i < CAPTURE_BYTES; i++) begin
                        if (pos_reg == 8'(i + 2)) begin
                            cap_next[i] = data_byte;
                        end
                    end
                    if ({1'b0, pos_reg} + 9'd1 == {1'b0, elen_next}) begin
                        commit   = 1'b1;
                        pos_next = 8'd0;
                    end else begin
                        pos_next = pos_reg + 8'd1;
                    end
                end
            end

            if (commit) begin
                case (kind_reg)
                    KIND_CPU: begin
                        if (cpu_fill_reg < CPU_CNT_W'(CPU_SLOTS)) begin
                            cpu_fill_next = cpu_fill_reg + CPU_CNT_W'(1);
                            if (cap_next[2][0]) begin
                                cpu_wr           = 1'b1;
                                enabled_cnt_next = enabled_cnt_reg + CPU_CNT_W'(1);
                            end
                        end
                    end
                    KIND_IOAPIC: begin
                        ioapic_id_next = cap_next[0];
                        ioapic_next    = cap_word4;
                        gsi_base_next  = cap_word8;
                    end
                    KIND_OVERRIDE: begin
                        if (ovr_fill_reg < OVR_CNT_W'(OVERRIDE_SLOTS)) begin
                            ovr_wr        = 1'b1;
                            ovr_fill_next = ovr_fill_reg + OVR_CNT_W'(1);
                        end
                    end
                    KIND_LAPIC_OVR: begin
                        if (elen_next >= LAPIC_OVR_MIN_LEN) begin
                            lapic_next = cap_word4;
                        end
                    end
                    default: begin
                    end
                endcase
            end

            if (offset_reg >= LEN_OFFSET_LAST &&
                {1'b0, offset_reg} + 33'd1 >= {1'b0, length_next}) begin
                valid_next = 1'b1;
            end
            offset_next = offset_reg + 32'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg      <= '0;
            length_reg      <= '0;
            pos_reg         <= '0;
            elen_reg        <= '0;
            kind_reg        <= '0;
            stopped_reg     <= 1'b0;
            valid_reg       <= 1'b0;
            lapic_reg       <= '0;
            ioapic_reg      <= '0;
            ioapic_id_reg   <= '0;
            gsi_base_reg    <= '0;
            cpu_fill_reg    <= '0;
            enabled_cnt_reg <= '0;
            ovr_fill_reg    <= '0;
        end else begin
            offset_reg      <= offset_next;
            length_reg      <= length_next;
            pos_reg         <= pos_next;
            elen_reg        <= elen_next;
            kind_reg        <= kind_next;
            stopped_reg     <= stopped_next;
            valid_reg       <= valid_next;
            lapic_reg       <= lapic_next;
            ioapic_reg      <= ioapic_next;
            ioapic_id_reg   <= ioapic_id_next;
            gsi_base_reg    <= gsi_base_next;
            cpu_fill_reg    <= cpu_fill_next;
            enabled_cnt_reg <= enabled_cnt_next;
            ovr_fill_reg    <= ovr_fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < CAPTURE_BYTES; i++) begin
            cap_reg[i] <= cap_next[i];
        end
        if (cpu_wr) begin
            enabled_apic[enabled_cnt_reg[CPU_IDX_W-1:0]] <= cap_next[1];
        end
        if (ovr_wr) begin
            ovr_table[ovr_fill_reg[OVR_IDX_W-1:0]] <= '{
                flags:  {cap_next[7], cap_next[6]},
                gsi:    cap_word4,
                source: cap_next[1]
            };
        end
    end

    assign status = '{
        table_valid:   valid_reg,
        lapic:         lapic_reg,
        ioapic:        ioapic_reg,
        ioapic_num:    ioapic_id_reg,
        gsi_base:      gsi_base_reg,
        enabled_cnt:   enabled_cnt_reg,
        override_fill: ovr_fill_reg
    };

    assign cpu_rd_apic = enabled_apic[cpu_rd_idx];
    assign ovr_rd      = ovr_table[ovr_rd_idx];

endmodule

FILE: design/madt_entry_parser.sv
// Top level of the streaming MADT parser: handshake, stage register and result register.
// An accepted transaction passes through the stage register and then the result register,
// and back-pressure on m_tready can hold it in either before the result is taken.
// Throughput: one transaction per cycle while m_tready does not stall the result register.
// Reset (aresetn low at a clock edge) clears the parser state, the fill counts and both
// valid flags; the tables are read only below their fill counts and are not cleared.
module madt_entry_parser (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [15:0]  s_tdata,   // [7:0] data_byte, [15:8] query_index
    input  logic [1:0]   s_tuser,   // [1:0] command
    output logic         m_tvalid,
    input  logic         m_tready,
    // [0] table_done, [32:1] lapic_base, [64:33] ioapic_base, [72:65] ioapic_number,
    // [104:73] gsi_base, [109:105] enabled_cpus, [114:110] override_count, [115] found,
    // [123:116] cpu_apic_number, [131:124] override_source, [163:132] override_gsi,
    // [179:164] override_flags, [183:180] zero
    output logic [183:0] m_tdata
);
    import madt_pkg::*;

    // The stage register holds the command and index of the transaction whose table
    // byte has just been applied, so the parser state seen here is the state right
    // after that transaction. The parser only moves again when this stage empties
    // or hands its transaction to the result register in the same cycle.
    logic         st_valid_reg;
    madt_cmd_t    st_cmd_reg;
    logic [7:0]   st_query_reg;

    logic         m_tvalid_reg;
    madt_result_t m_tdata_reg, m_tdata_next;

    logic         out_ready;
    logic         st_advance;
    logic         s_accept;
    logic         byte_en;

    madt_status_t status;
    logic [7:0]   cpu_rd_apic;
    madt_ovr_t    ovr_rd;
    logic         cpu_hit;
    logic         ovr_hit;

    // The result register can load when it is empty or being drained this cycle.
    assign out_ready  = !m_tvalid_reg || m_tready;
    assign st_advance = st_valid_reg && out_ready;
    assign s_tready   = !st_valid_reg || out_ready;
    assign s_accept   = s_tvalid && s_tready;
    assign byte_en    = s_accept && (madt_cmd_t'(s_tuser) == CMD_TABLE_BYTE);

    madt_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .byte_en     (byte_en),
        .data_byte   (s_tdata[7:0]),
        .cpu_rd_idx  (st_query_reg[CPU_IDX_W-1:0]),
        .ovr_rd_idx  (st_query_reg[OVR_IDX_W-1:0]),
        .status      (status),
        .cpu_rd_apic (cpu_rd_apic),
        .ovr_rd      (ovr_rd)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                st_valid_reg <= 1'b1;
            end else if (st_advance) begin
                st_valid_reg <= 1'b0;
            end
            if (st_advance) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            st_cmd_reg   <= madt_cmd_t'(s_tuser);
            st_query_reg <= s_tdata[15:8];
        end
        if (st_advance) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    // A CPU query counts only enabled processors and only once the table is done.
    // An override query is answered from whatever records are stored so far.
    always_comb begin
        cpu_hit = 1'b0;
        ovr_hit = 1'b0;
        case (st_cmd_reg)
            CMD_QUERY_CPU: begin
                cpu_hit = status.table_valid &&
                          (QCMP_W'(st_query_reg) < QCMP_W'(status.enabled_cnt));
            end
            CMD_QUERY_OVR: begin
                ovr_hit = QCMP_W'(st_query_reg) < QCMP_W'(status.override_fill);
            end
            default: begin
            end
        endcase

        m_tdata_next.pad             = '0;
        m_tdata_next.table_done      = status.table_valid;
        m_tdata_next.lapic_base      = status.table_valid ? status.lapic : LAPIC_DEFAULT;
        m_tdata_next.ioapic_base     = status.table_valid ? status.ioapic : IOAPIC_DEFAULT;
        m_tdata_next.ioapic_number   = status.table_valid ? status.ioapic_num : 8'd0;
        m_tdata_next.gsi_base        = status.table_valid ? status.gsi_base : 32'd0;
        // With no enabled processor found, or before the table is done, the boot processor is still reported.
        m_tdata_next.enabled_cpus    = (status.table_valid && status.enabled_cnt != '0) ?
                                       5'(status.enabled_cnt) : 5'd1;
        m_tdata_next.override_count  = 5'(status.override_fill);
        m_tdata_next.found           = cpu_hit || ovr_hit;
        m_tdata_next.cpu_apic_number = cpu_hit ? cpu_rd_apic : 8'd0;
        m_tdata_next.override_source = ovr_hit ? ovr_rd.source : 8'd0;
        m_tdata_next.override_gsi    = ovr_hit ? ovr_rd.gsi : 32'd0;
        m_tdata_next.override_flags  = ovr_hit ? ovr_rd.flags : 16'd0;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

FILE: design/madt_checker.sv
// Port-level checker for the MADT parser, bound to the top level.
module madt_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [183:0] m_tdata
);
    import madt_pkg::*;

    madt_result_t res;
    logic         done_seen_reg;
    logic [4:0]   ovr_count_reg;
    logic         m_accept;

    assign res      = m_tdata;
    assign m_accept = m_tvalid && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_seen_reg <= 1'b0;
            ovr_count_reg <= '0;
        end else if (m_accept) begin
            done_seen_reg <= done_seen_reg || res.table_done;
            ovr_count_reg <= res.override_count;
        end
    end

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_done_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && done_seen_reg |-> res.table_done)
        else $error("table_done dropped after the table completed");

    a_ovr_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> res.override_count >= ovr_count_reg)
        else $error("override count went backwards");

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !res.found |-> res.cpu_apic_number == 8'd0 &&
            res.override_source == 8'd0 && res.override_gsi == 32'd0 &&
            res.override_flags == 16'd0)
        else $error("query fields nonzero without a hit");

endmodule

bind madt_entry_parser madt_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
